// File: design/audio_envelope_servo_driver_core_defines.svh
// Assertion macros shared by the envelope servo driver RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef AUDIO_ENVELOPE_SERVO_DRIVER_CORE_DEFINES_SVH
`define AUDIO_ENVELOPE_SERVO_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AESD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AESD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/aesd_pkg.sv
// Package for the audio envelope servo driver: widths, register map, reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aesd_pkg;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int PULSE_W  = 16;
    localparam int GAIN_W   = 17;
    localparam int SUM_W    = 27;
    localparam int FRAC_W   = 8;
    localparam int DVD_W    = SUM_W + FRAC_W;

    // normalized mean: n / 2^22, capped at one
    localparam int N_FRAC = 22;
    localparam int N_W    = N_FRAC + 1;
    localparam logic [N_W-1:0] N_ONE = N_W'(1) << N_FRAC;

    // shared multiplier
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // target / delta and smoothed pulse (16 fraction bits)
    localparam int TGT_W  = 18;
    localparam int NUM_W  = 40;
    localparam int SM_W   = 36;
    localparam int SM_FRAC = 16;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_PULSE_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PULSE_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLEW_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SMOOTH_GAIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEADBAND    = 3'd5;

    localparam logic [PULSE_W-1:0] PULSE_MIN_RST   = 16'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST   = 16'd2000;
    localparam logic [15:0]        THRESHOLD_RST   = 16'd500;
    localparam logic [15:0]        SLEW_LIMIT_RST  = 16'd100;
    localparam logic [GAIN_W-1:0]  SMOOTH_GAIN_RST = 17'd32768;
    localparam logic [15:0]        DEADBAND_RST    = 16'd2;

endpackage

`default_nettype wire

// File: design/aesd_div.sv
// Restoring divider, one quotient bit per cycle, for the block mean.
// Standalone; widths come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module aesd_div #(
    parameter int DVD_W = 35,
    parameter int DVS_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    // shift next dividend bit into the partial remainder
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend bits leave at the top as quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/audio_envelope_servo_driver_core.sv
// Audio envelope servo driver: summing the magnitudes of a block of samples one per cycle while
// sample_stall is low, then turning the block mean into a slew-limited, smoothed servo pulse. The
// transaction that closes a block (last_in_block set, or the count reaching MAX_BLOCK) starts a
// sequence with sample_stall high throughout. A block below the sound threshold ends it after
// threshold * count and then the compare. Otherwise it goes on to the divide step, which waits for
// the done flag of the bit-serial divider forming the 35-bit quotient sum*256/count; the other
// steps are single steps that share one 24x18 multiplier (threshold * count, mean * span,
// delta * gain) with a compare or clamp after each. A pulse that clears the deadband waits until
// the output register is free. A pulse is held in an output register until the consumer takes it,
// while new samples are accepted.
// Depends on aesd_pkg, aesd_div and audio_envelope_servo_driver_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "audio_envelope_servo_driver_core_defines.svh"

module audio_envelope_servo_driver_core #(
    parameter int MAX_BLOCK = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aesd_pkg::ADDR_W-1:0]         paddr,
    input  logic [aesd_pkg::DATA_W-1:0]         pwdata,
    output logic [aesd_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,

    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [aesd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_in_block,

    // pulse channel
    output logic                                pulse_valid,
    input  logic                                pulse_stall,
    output logic [aesd_pkg::PULSE_W-1:0]        servo_pulse
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    typedef enum logic [3:0] {
        S_IDLE,     // accumulate samples
        S_THR,      // multiplier: threshold * count
        S_CHK,      // compare sum against it, launch divider
        S_DIV,      // wait for the mean
        S_MAP,      // multiplier: capped mean * span
        S_TGT,      // target, range clamp, slew clamp
        S_SMOOTH,   // multiplier: delta * gain
        S_CLAMP,    // smoothed pulse, range clamp
        S_DEAD,     // deadband test
        S_OUT       // hand the pulse to the output register
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [aesd_pkg::PULSE_W-1:0]  pulse_min_reg;
    logic [aesd_pkg::PULSE_W-1:0]  pulse_max_reg;
    logic [15:0]                   threshold_reg;
    logic [15:0]                   slew_limit_reg;
    logic [aesd_pkg::GAIN_W-1:0]   smooth_gain_reg;
    logic [15:0]                   deadband_reg;

    logic                          cfg_write;
    logic [aesd_pkg::IDX_W-1:0]    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[aesd_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg   <= aesd_pkg::PULSE_MIN_RST;
            pulse_max_reg   <= aesd_pkg::PULSE_MAX_RST;
            threshold_reg   <= aesd_pkg::THRESHOLD_RST;
            slew_limit_reg  <= aesd_pkg::SLEW_LIMIT_RST;
            smooth_gain_reg <= aesd_pkg::SMOOTH_GAIN_RST;
            deadband_reg    <= aesd_pkg::DEADBAND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                aesd_pkg::REG_PULSE_MIN:   pulse_min_reg   <= pwdata[15:0];
                aesd_pkg::REG_PULSE_MAX:   pulse_max_reg   <= pwdata[15:0];
                aesd_pkg::REG_THRESHOLD:   threshold_reg   <= pwdata[15:0];
                aesd_pkg::REG_SLEW_LIMIT:  slew_limit_reg  <= pwdata[15:0];
                aesd_pkg::REG_SMOOTH_GAIN: smooth_gain_reg <= pwdata[aesd_pkg::GAIN_W-1:0];
                aesd_pkg::REG_DEADBAND:    deadband_reg    <= pwdata[15:0];
                default: ;  // unmapped addresses are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            aesd_pkg::REG_PULSE_MIN:   prdata = aesd_pkg::DATA_W'(pulse_min_reg);
            aesd_pkg::REG_PULSE_MAX:   prdata = aesd_pkg::DATA_W'(pulse_max_reg);
            aesd_pkg::REG_THRESHOLD:   prdata = aesd_pkg::DATA_W'(threshold_reg);
            aesd_pkg::REG_SLEW_LIMIT:  prdata = aesd_pkg::DATA_W'(slew_limit_reg);
            aesd_pkg::REG_SMOOTH_GAIN: prdata = aesd_pkg::DATA_W'(smooth_gain_reg);
            aesd_pkg::REG_DEADBAND:    prdata = aesd_pkg::DATA_W'(deadband_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    state_t                              state_reg,       state_next;
    logic [aesd_pkg::SUM_W-1:0]          sum_reg,         sum_next;
    logic [CNT_W-1:0]                    cnt_reg,         cnt_next;
    logic [aesd_pkg::SUM_W-1:0]          blk_sum_reg,     blk_sum_next;
    logic [CNT_W-1:0]                    blk_cnt_reg,     blk_cnt_next;
    logic signed [aesd_pkg::TGT_W-1:0]   delta_reg,       delta_next;
    logic signed [aesd_pkg::SM_W-1:0]    sm_reg,          sm_next;
    logic [aesd_pkg::PULSE_W-1:0]        last_pulse_reg,  last_pulse_next;
    logic                                pulse_valid_reg, pulse_valid_next;
    logic [aesd_pkg::PULSE_W-1:0]        servo_pulse_reg, servo_pulse_next;
    logic signed [aesd_pkg::PROD_W-1:0]  prod_reg;

    // ------------------------------------------------------------------
    // Accumulator datapath
    // ------------------------------------------------------------------
    logic [aesd_pkg::MAG_W-1:0]  mag;
    logic [aesd_pkg::SUM_W-1:0]  acc_sum;
    logic [CNT_W-1:0]            acc_cnt;
    logic                        acc_end;
    logic                        sample_take;

    // -32768 becomes 32768, hence the extra bit
    assign mag = sample[aesd_pkg::SAMPLE_W-1]
               ? aesd_pkg::MAG_W'(-$signed({sample[aesd_pkg::SAMPLE_W-1], sample}))
               : {1'b0, sample};
    assign acc_sum     = sum_reg + aesd_pkg::SUM_W'(mag);
    assign acc_cnt     = cnt_reg + CNT_W'(1);
    assign acc_end     = last_in_block || (acc_cnt == CNT_W'(MAX_BLOCK));
    assign sample_take = sample_valid && !sample_stall;

    // ------------------------------------------------------------------
    // Mean divider
    // ------------------------------------------------------------------
    logic                          div_start;
    logic                          div_done;
    logic [aesd_pkg::DVD_W-1:0]    div_q;
    logic [aesd_pkg::N_W-1:0]      n_val;

    aesd_div #(
        .DVD_W (aesd_pkg::DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({blk_sum_reg, aesd_pkg::FRAC_W'(0)}),
        .divisor  (blk_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // mean/16384 capped at one, as n / 2^22
    assign n_val = (div_q > aesd_pkg::DVD_W'(aesd_pkg::N_ONE))
                 ? aesd_pkg::N_ONE : div_q[aesd_pkg::N_W-1:0];

    // ------------------------------------------------------------------
    // Shared multiplier, operands steered by the sequencer
    // ------------------------------------------------------------------
    logic signed [aesd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [aesd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [16:0]                  span;

    assign span = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});

    always_comb
    begin
        case (state_reg)
            S_THR:
            begin
                mul_a = $signed(aesd_pkg::MUL_A_W'(threshold_reg));
                mul_b = $signed(aesd_pkg::MUL_B_W'(blk_cnt_reg));
            end
            S_MAP:
            begin
                mul_a = $signed(aesd_pkg::MUL_A_W'(n_val));
                mul_b = aesd_pkg::MUL_B_W'(span);
            end
            S_SMOOTH:
            begin
                mul_a = aesd_pkg::MUL_A_W'(delta_reg);
                mul_b = $signed(aesd_pkg::MUL_B_W'(smooth_gain_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Step datapath
    // ------------------------------------------------------------------
    logic                                thr_fail;
    logic signed [aesd_pkg::NUM_W-1:0]   numer;
    logic signed [aesd_pkg::TGT_W-1:0]   target;
    logic signed [aesd_pkg::TGT_W-1:0]   tgt_c;
    logic signed [aesd_pkg::TGT_W-1:0]   pmin_t;
    logic signed [aesd_pkg::TGT_W-1:0]   pmax_t;
    logic signed [aesd_pkg::TGT_W-1:0]   prev_t;
    logic signed [aesd_pkg::TGT_W-1:0]   slew_t;
    logic signed [aesd_pkg::TGT_W-1:0]   delta_raw;
    logic signed [aesd_pkg::TGT_W-1:0]   delta_c;
    logic signed [aesd_pkg::SM_W-1:0]    prev_s;
    logic signed [aesd_pkg::SM_W-1:0]    pmin_s;
    logic signed [aesd_pkg::SM_W-1:0]    pmax_s;
    logic signed [aesd_pkg::SM_W-1:0]    sm_raw;
    logic signed [aesd_pkg::SM_W-1:0]    sm_c;
    logic signed [aesd_pkg::SM_W-1:0]    diff;
    logic signed [aesd_pkg::SM_W-1:0]    diff_abs;
    logic signed [aesd_pkg::SM_W-1:0]    dead_s;
    logic                                emit;
    logic                                out_load;

    always_comb
    begin
        // mean below threshold, tested exactly as sum < threshold * count
        thr_fail = aesd_pkg::PROD_W'(blk_sum_reg) < $unsigned(prod_reg);

        pmin_t = $signed({2'b00, pulse_min_reg});
        pmax_t = $signed({2'b00, pulse_max_reg});
        prev_t = $signed({2'b00, last_pulse_reg});
        slew_t = $signed({2'b00, slew_limit_reg});

        // linear map; never negative, even with an inverted range
        numer  = $signed({2'b00, pulse_min_reg, aesd_pkg::N_FRAC'(0)})
               + $signed(prod_reg[aesd_pkg::NUM_W-1:0]);
        target = numer[aesd_pkg::NUM_W-1:aesd_pkg::N_FRAC];
        // lower bound is tested first
        tgt_c  = (target < pmin_t) ? pmin_t : ((target > pmax_t) ? pmax_t : target);

        delta_raw = tgt_c - prev_t;
        delta_c   = (delta_raw < -slew_t) ? -slew_t
                  : ((delta_raw > slew_t) ? slew_t : delta_raw);

        prev_s = $signed({4'b0000, last_pulse_reg, aesd_pkg::SM_FRAC'(0)});
        pmin_s = $signed({4'b0000, pulse_min_reg, aesd_pkg::SM_FRAC'(0)});
        pmax_s = $signed({4'b0000, pulse_max_reg, aesd_pkg::SM_FRAC'(0)});
        dead_s = $signed({4'b0000, deadband_reg, aesd_pkg::SM_FRAC'(0)});

        sm_raw = prev_s + $signed(prod_reg[aesd_pkg::SM_W-1:0]);
        sm_c   = (sm_raw < pmin_s) ? pmin_s : ((sm_raw > pmax_s) ? pmax_s : sm_raw);

        diff     = sm_reg - prev_s;
        diff_abs = (diff < 0) ? -diff : diff;
        emit     = diff_abs > dead_s;
    end

    // output register free this cycle (empty, or being taken)
    assign out_load = (state_reg == S_OUT) && (!pulse_valid_reg || !pulse_stall);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        cnt_next         = cnt_reg;
        blk_sum_next     = blk_sum_reg;
        blk_cnt_next     = blk_cnt_reg;
        delta_next       = delta_reg;
        sm_next          = sm_reg;
        last_pulse_next  = last_pulse_reg;
        servo_pulse_next = servo_pulse_reg;
        pulse_valid_next = pulse_valid_reg && pulse_stall;
        div_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    if (acc_end)
                    begin
                        // sum and count restart whether or not a pulse follows
                        blk_sum_next = acc_sum;
                        blk_cnt_next = acc_cnt;
                        sum_next     = '0;
                        cnt_next     = '0;
                        state_next   = S_THR;
                    end
                    else
                    begin
                        sum_next = acc_sum;
                        cnt_next = acc_cnt;
                    end
                end
            end
            S_THR:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (thr_fail)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_TGT;
            end
            S_TGT:
            begin
                delta_next = delta_c;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                sm_next    = sm_c;
                state_next = S_DEAD;
            end
            S_DEAD:
            begin
                state_next = emit ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    servo_pulse_next = sm_reg[aesd_pkg::SM_FRAC+aesd_pkg::PULSE_W-1:
                                              aesd_pkg::SM_FRAC];
                    last_pulse_next  = sm_reg[aesd_pkg::SM_FRAC+aesd_pkg::PULSE_W-1:
                                              aesd_pkg::SM_FRAC];
                    pulse_valid_next = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            blk_sum_reg     <= '0;
            blk_cnt_reg     <= '0;
            delta_reg       <= '0;
            sm_reg          <= '0;
            last_pulse_reg  <= aesd_pkg::PULSE_MIN_RST;
            pulse_valid_reg <= 1'b0;
            servo_pulse_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sum_reg         <= sum_next;
            cnt_reg         <= cnt_next;
            blk_sum_reg     <= blk_sum_next;
            blk_cnt_reg     <= blk_cnt_next;
            delta_reg       <= delta_next;
            sm_reg          <= sm_next;
            last_pulse_reg  <= last_pulse_next;
            pulse_valid_reg <= pulse_valid_next;
            servo_pulse_reg <= servo_pulse_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign pulse_valid  = pulse_valid_reg;
    assign servo_pulse  = servo_pulse_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AESD_ASSERT_IMP(a_acc_clear, state_reg != S_IDLE, {sum_reg, cnt_reg} == '0, "sum not cleared")
    `AESD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg < CNT_W'(MAX_BLOCK), "count at block limit")
    `AESD_ASSERT_IMP(a_pulse_track, pulse_valid_reg, servo_pulse_reg == last_pulse_reg, "pulse skew")
    `AESD_ASSERT_IMP(a_div_done, div_done, state_reg == S_DIV, "stray divider done")
    `AESD_ASSERT_NXT(a_out_load, out_load, pulse_valid_reg && state_reg == S_IDLE, "pulse not loaded")

endmodule

`default_nettype wire
